// File: rtl/core/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg: shared types and constants of the multi-voice sample mixer
// Command codes, field widths and voice reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package mvsm_pkg;
   localparam int VOICES = 8;
   localparam int VOICE_W = 3;
   localparam int SAMPLE_AW = 16;
   localparam int BLOCK_MAX = 64;
   localparam int FRAME_W = 6;
   localparam int LEN_W = 17;
   localparam int POS_W = 29;

   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_DEFINE = 3'd1;
   localparam logic [2:0] FUNC_PLAY   = 3'd2;
   localparam logic [2:0] FUNC_SETPLAY = 3'd3;
   localparam logic [2:0] FUNC_RESET  = 3'd4;
   localparam logic [2:0] FUNC_RENDER = 3'd5;

   localparam logic [15:0] GAIN_ONE = 16'd16384;
   localparam logic [15:0] STEP_ONE = 16'd4096;
   localparam logic [LEN_W-1:0] LEN_MAX = 17'd65536;

   // one multiply-accumulate request to the shared unit
   typedef struct packed {
      logic               clear;
      logic               add;
      logic signed [15:0] sample;
      logic [15:0]        gain;
   } mac_ctl_type;
endpackage
`default_nettype wire

// File: rtl/core/mvsm_mac.sv
// ----------------------------------------------------------------------------
// mvsm_mac: shared multiply-accumulate unit
// Registers the sample-gain product, then adds it to the accumulator or clears it.
// ----------------------------------------------------------------------------
`default_nettype none
module mvsm_mac import mvsm_pkg::*; (
   input  wire logic         clock,
   input  wire mac_ctl_type  ctl,
   output logic signed [35:0] acc
);
   logic signed [32:0] prod_ff, prod_in;
   logic               add_ff, add_in, clr_ff, clr_in;
   logic signed [35:0] acc_ff, acc_in;

   // form the product and the next accumulator value
   always_comb begin
      prod_in = 33'(ctl.sample) * $signed({1'b0, ctl.gain});
      add_in  = ctl.add;
      clr_in  = ctl.clear;
      acc_in  = acc_ff;
      if (clr_ff) begin
         acc_in = '0;
      end else if (add_ff) begin
         acc_in = acc_ff + 36'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      add_ff  <= add_in;
      clr_ff  <= clr_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

// File: rtl/core/multi_voice_sample_mixer_unit.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_unit: wavetable clip player and mixer
// Sequencer over voices and frames driving one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the req_ channel (func in tdata bits 2:0).
// Write, define, play, set playing and reset take one transfer each
// and produce nothing on rsp_.
// A render of n frames (n capped at BLOCK_MAX) gives n transfers on
// rsp_, the last with tlast. Each frame is worked voice by voice
// through one sample memory read port and the shared multiplier, then
// drained, rounded and saturated into the output register.
// Position updates then take one voice per cycle.
// req_tready is low while an item is in work. Each frame waits in the
// output register until rsp_tready; the sequencer works on the next frame
// and holds once that one is ready to leave.
// Reset clears voice state and sets gain and step back to unity; sample memory is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_voice_sample_mixer_unit import mvsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func[2:0] clip_id[5:3] address[21:6] sample_value[37:22]
   // clip_length[54:38] loop_flag[55] volume[71:56] pitch[87:72]
   // unstoppable[88] enable[89] paused[90] frame_count[97:91]
   input  wire logic [103:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // sample_out[15:0]
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_CMD = 3'd1, ST_VOICE = 3'd2,
                          ST_DRAIN = 3'd3, ST_OUT = 3'd4, ST_UPD = 3'd5;

   logic [6:0] fcnt;
   assign fcnt = req_tdata[97:91];

   logic [103:0] cmd_ff;
   logic [2:0] st_ff;
   logic [15:0] base_ff [VOICES];
   logic [LEN_W-1:0] len_ff [VOICES];
   logic [POS_W-1:0] pos_ff [VOICES];
   logic [15:0] gain_ff [VOICES], step_ff [VOICES];
   logic [VOICES-1:0] play_ff, loop_ff, keep_ff;
   logic [15:0] mem [2**SAMPLE_AW];
   logic [15:0] rd_ff;
   logic [VOICE_W-1:0] v_ff;
   logic [1:0] ph_ff;
   logic [6:0] n_ff, fr_ff;
   logic [POS_W+6:0] off_ff;
   logic out_v_ff, out_l_ff;
   logic [15:0] out_d_ff;
   mac_ctl_type mctl;
   logic signed [35:0] acc;

   mvsm_mac u_mac (.clock(clock), .ctl(mctl), .acc(acc));

   // voice sample address for current frame
   logic [35:0] idx_full;
   logic [22:0] idx;
   logic in_clip, active;
   assign idx_full = 36'(pos_ff[v_ff]) + 36'(fr_ff) * 36'(step_ff[v_ff]);
   assign idx = idx_full[34:12];
   assign in_clip = ({6'd0, len_ff[v_ff]} > idx);
   assign active = play_ff[v_ff] & (keep_ff[v_ff] | ~cmd_ff[90]);

   // play gain: round-half-up of volume * 0.4 by a reciprocal of ten
   logic [19:0] gain_num;
   logic [39:0] gain_prod;
   assign gain_num = {2'd0, cmd_ff[71:56], 2'd0} + 20'd5;
   assign gain_prod = 40'(gain_num) * 40'd419431;

   always_ff @(posedge clock) begin
      rd_ff <= mem[16'(base_ff[v_ff] + idx[15:0])];
      if (st_ff == ST_CMD && cmd_ff[2:0] == FUNC_WRITE) begin
         mem[cmd_ff[21:6]] <= cmd_ff[37:22];
      end
   end

   // round and saturate the mix
   logic signed [35:0] rq;
   logic signed [21:0] rs;
   logic [15:0] sat;
   assign rq = acc + 36'sd8192;
   assign rs = rq[35:14];
   assign sat = (rs > 22'sd32767) ? 16'h7fff :
                (rs < -22'sd32768) ? 16'h8000 : rs[15:0];

   logic [POS_W+7:0] npos;
   assign npos = 37'(pos_ff[v_ff]) + 37'(n_ff) * 37'(step_ff[v_ff]);

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tlast  = out_l_ff;

   always_comb begin
      mctl = '0;
      mctl.sample = rd_ff;
      mctl.gain = gain_ff[v_ff];
      if (st_ff == ST_VOICE && ph_ff == 2'd2) begin
         mctl.add = active & in_clip;
      end
      if ((st_ff == ST_OUT && !out_v_ff) || st_ff == ST_CMD) begin
         mctl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         play_ff <= '0; loop_ff <= '0; keep_ff <= '0;
         for (int k = 0; k < VOICES; k++) begin
            base_ff[k] <= '0; len_ff[k] <= '0; pos_ff[k] <= '0;
            gain_ff[k] <= GAIN_ONE; step_ff[k] <= STEP_ONE;
         end
      end else begin
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff <= req_tdata;
                  n_ff <= (fcnt > 7'(BLOCK_MAX)) ? 7'(BLOCK_MAX) : fcnt;
                  fr_ff <= '0; v_ff <= '0; ph_ff <= '0;
                  st_ff <= ST_CMD;
               end
            end
            ST_CMD: begin
               st_ff <= ST_IDLE;
               case (cmd_ff[2:0])
                  FUNC_DEFINE: begin
                     base_ff[cmd_ff[5:3]] <= cmd_ff[21:6];
                     len_ff[cmd_ff[5:3]] <= (cmd_ff[54:38] > LEN_MAX) ?
                                            LEN_MAX : cmd_ff[54:38];
                     play_ff[cmd_ff[5:3]] <= 1'b0;
                     pos_ff[cmd_ff[5:3]] <= '0;
                  end
                  FUNC_PLAY: begin
                     if (len_ff[cmd_ff[5:3]] != '0) begin
                        play_ff[cmd_ff[5:3]] <= 1'b1;
                        loop_ff[cmd_ff[5:3]] <= cmd_ff[55];
                        pos_ff[cmd_ff[5:3]] <= '0;
                        gain_ff[cmd_ff[5:3]] <= gain_prod[37:22];
                        step_ff[cmd_ff[5:3]] <= cmd_ff[87:72];
                        keep_ff[cmd_ff[5:3]] <= cmd_ff[88];
                     end
                  end
                  FUNC_SETPLAY: begin
                     if (len_ff[cmd_ff[5:3]] != '0)
                        play_ff[cmd_ff[5:3]] <= cmd_ff[89];
                  end
                  FUNC_RESET: begin
                     play_ff <= '0; loop_ff <= '0;
                     for (int k = 0; k < VOICES; k++) begin
                        pos_ff[k] <= '0; gain_ff[k] <= GAIN_ONE;
                        step_ff[k] <= STEP_ONE;
                     end
                  end
                  FUNC_RENDER: begin
                     st_ff <= (n_ff == '0) ? ST_UPD : ST_VOICE;
                  end
                  default: ;
               endcase
            end
            // phases: address settle, memory read, multiply, accumulate
            ST_VOICE: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff == 2'd3) begin
                  v_ff <= v_ff + 1'b1;
                  if (v_ff == VOICE_W'(VOICES - 1)) st_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff == 2'd1) begin
                  ph_ff <= '0;
                  st_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!out_v_ff) begin
                  out_v_ff <= 1'b1;
                  out_d_ff <= sat;
                  out_l_ff <= (fr_ff + 7'd1 == n_ff);
                  fr_ff <= fr_ff + 7'd1;
                  v_ff <= '0;
                  st_ff <= (fr_ff + 7'd1 == n_ff) ? ST_UPD : ST_VOICE;
               end
            end
            ST_UPD: begin
               if (active) begin
                  pos_ff[v_ff] <= npos[POS_W-1:0];
                  if ({8'd0, npos[POS_W-1:12]} >= {8'd0, len_ff[v_ff]}) begin
                     pos_ff[v_ff] <= '0;
                     if (!loop_ff[v_ff]) begin
                        play_ff[v_ff] <= 1'b0;
                        gain_ff[v_ff] <= GAIN_ONE;
                        step_ff[v_ff] <= STEP_ONE;
                     end
                  end
               end
               v_ff <= v_ff + 1'b1;
               if (v_ff == VOICE_W'(VOICES - 1)) st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // a frame never appears outside a render
   a_out_render: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(st_ff) == ST_OUT)
      else $error("frame outside render");
   // no new command while a frame other than the last waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_l_ff) |-> !req_tready)
      else $error("ready during render");
endmodule
`default_nettype wire
